// ===== rtl/pn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the path normaliser: sizes, character codes, operation and
// state codes, and the structs passed between the front, queue and back.
// Depends on nothing; every other file of the block uses it.
package pn_pkg;

   // Store size and derived widths
   localparam int BUFFER_BYTES = 64;
   localparam int ADDR_W       = $clog2(BUFFER_BYTES);
   localparam int LEN_W        = 7;
   localparam int POS_W        = LEN_W + 1;
   localparam int BYTE_W       = 8;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 7;

   // Character codes
   localparam logic [BYTE_W-1:0] SLASH_CHAR = 8'h2F;
   localparam logic [BYTE_W-1:0] DOT_CHAR   = 8'h2E;
   localparam logic [BYTE_W-1:0] NUL_CHAR   = 8'h00;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ABSOLUTE_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_CAPACITY = 1'b1;
   localparam logic [LEN_W-1:0]     CAP_RESET           = 7'd64;

   // Request commands
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // Classified operations handed from front to back
   typedef enum logic [1:0] {
      OP_CHAR,
      OP_SLASH,
      OP_ABS_CHAR,
      OP_END
   } op_kind_type;

   typedef struct packed {
      op_kind_type             kind;
      logic [BYTE_W-1:0]       char_byte;
   } op_type;

   // Classification of the open component
   typedef enum logic [1:0] {
      DOTS_OTHER,
      DOTS_ONE,
      DOTS_TWO
   } dots_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_CHK,
      ST_FIN,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_WAIT
   } state_type;

   // Configuration seen by front and back
   typedef struct packed {
      logic                    absolute_mode;
      logic [LEN_W-1:0]        output_capacity;
   } cfg_type;

endpackage

// ===== rtl/pn_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the path normaliser: request, response and
// register write. Depends on pn_pkg for the field widths.

interface pn_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [pn_pkg::BYTE_W-1:0]        char_byte;

   modport source (output valid, output command, output char_byte, input ready);
   modport sink   (input valid, input command, input char_byte, output ready);
endinterface

interface pn_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pn_pkg::BYTE_W-1:0]        out_byte;
   logic                             last;
   logic                             status;

   modport source (output valid, output out_byte, output last, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input last, input status,
                   output ready);
endinterface

interface pn_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pn_pkg::CSR_IDX_W-1:0]     index;
   logic [pn_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pn_front.sv =====
`timescale 1ns / 1ps
// Front part of the path normaliser: accepts request transactions and
// classifies each into an operation for the back part. Uses pn_pkg, pn_if.
module pn_front (
   pn_req_if.sink            req,
   input  pn_pkg::cfg_type   cfg,
   input  logic              q_full,
   output logic              q_push,
   output pn_pkg::op_type    q_op
);

   // Accept whenever the queue has room.
   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   // Sort the item by command, mode and character.
   always_comb begin
      q_op.char_byte = req.char_byte;
      if (req.command == pn_pkg::CMD_END) begin
         q_op.kind = pn_pkg::OP_END;
      end else if (cfg.absolute_mode) begin
         q_op.kind = pn_pkg::OP_ABS_CHAR;
      end else if (req.char_byte == pn_pkg::SLASH_CHAR) begin
         q_op.kind = pn_pkg::OP_SLASH;
      end else begin
         q_op.kind = pn_pkg::OP_CHAR;
      end
   end

endmodule

// ===== rtl/pn_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified operations between front and back parts.
// Uses pn_pkg for the operation struct.
module pn_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pn_pkg::op_type    push_op,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output pn_pkg::op_type    head_op
);

   pn_pkg::op_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_op   = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/pn_back.sv =====
`timescale 1ns / 1ps
// Back part of the path normaliser: carries out queued operations on the
// path store, walks back over the store on "..", and emits the result.
// Uses pn_pkg and pn_if.
module pn_back (
   input  logic              clock,
   input  logic              reset,
   input  pn_pkg::cfg_type   cfg,
   input  logic              q_valid,
   input  pn_pkg::op_type    q_op,
   output logic              q_pop,
   pn_rsp_if.source          rsp
);

   localparam logic [pn_pkg::LEN_W-1:0] BUF_LEN = pn_pkg::LEN_W'(pn_pkg::BUFFER_BYTES);

   // Path store
   logic [pn_pkg::BYTE_W-1:0] store_mem [pn_pkg::BUFFER_BYTES];
   logic                      mem_we;
   logic [pn_pkg::ADDR_W-1:0] mem_waddr;
   logic [pn_pkg::BYTE_W-1:0] mem_wdata;
   logic [pn_pkg::ADDR_W-1:0] mem_raddr;
   logic [pn_pkg::BYTE_W-1:0] rd_data_ff;

   // Path state
   pn_pkg::state_type         state_ff, state_in;
   logic [pn_pkg::LEN_W-1:0]  kept_ff, kept_in;
   logic [pn_pkg::LEN_W-1:0]  comp_ff, comp_in;
   pn_pkg::dots_type          dots_ff, dots_in;
   logic                      lead_ff, lead_in;
   logic                      ovf_ff, ovf_in;
   logic                      finish_ff, finish_in;
   logic [pn_pkg::ADDR_W-1:0] emit_idx_ff, emit_idx_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [pn_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_status_ff, rsp_status_in;

   // Derived values
   logic [pn_pkg::LEN_W-1:0]  eff_cap;
   logic                      sep;
   logic [pn_pkg::POS_W-1:0]  pos;
   logic                      app_full;
   logic                      abs_full;
   logic                      close_pop;
   logic                      close_app;
   logic                      fin_error;
   logic                      emit_list;
   logic                      rsp_taken;
   pn_pkg::state_type         pop_done_state;

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.last   = rsp_last_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp_taken  = rsp_valid_ff && rsp.ready;

   // Capacity, placement and fit checks
   always_comb begin
      eff_cap   = (cfg.output_capacity > BUF_LEN) ? BUF_LEN : cfg.output_capacity;
      sep       = (kept_ff != '0);
      pos       = {1'b0, kept_ff} + {{pn_pkg::LEN_W{1'b0}}, sep} + {1'b0, comp_ff};
      app_full  = (pos + pn_pkg::POS_W'(1)) > {1'b0, eff_cap};
      abs_full  = (({1'b0, kept_ff} + pn_pkg::POS_W'(2)) > {1'b0, eff_cap})
                  || (kept_ff >= BUF_LEN);
      close_pop = !ovf_ff && (comp_ff != '0) && (dots_ff == pn_pkg::DOTS_TWO);
      close_app = !ovf_ff && (comp_ff != '0) && (dots_ff != pn_pkg::DOTS_ONE)
                  && (dots_ff != pn_pkg::DOTS_TWO);
      fin_error = ovf_ff || (eff_cap < pn_pkg::LEN_W'(2));
      emit_list = !fin_error && (kept_ff != '0);
      pop_done_state = finish_ff ? pn_pkg::ST_FIN : pn_pkg::ST_IDLE;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pn_pkg::ST_IDLE: begin
            if (q_valid) begin
               case (q_op.kind)
                  pn_pkg::OP_SLASH: begin
                     if (!lead_ff && close_pop) state_in = pn_pkg::ST_POP_RD;
                  end
                  pn_pkg::OP_END: begin
                     if (!cfg.absolute_mode && close_pop) state_in = pn_pkg::ST_POP_RD;
                     else state_in = pn_pkg::ST_FIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pn_pkg::ST_POP_RD: begin
            state_in = (kept_ff == '0) ? pop_done_state : pn_pkg::ST_POP_CHK;
         end
         pn_pkg::ST_POP_CHK: begin
            state_in = (rd_data_ff == pn_pkg::SLASH_CHAR) ? pop_done_state
                                                           : pn_pkg::ST_POP_RD;
         end
         pn_pkg::ST_FIN: begin
            state_in = emit_list ? pn_pkg::ST_EMIT_RD : pn_pkg::ST_WAIT;
         end
         pn_pkg::ST_EMIT_RD: state_in = pn_pkg::ST_EMIT_LD;
         pn_pkg::ST_EMIT_LD: state_in = pn_pkg::ST_WAIT;
         pn_pkg::ST_WAIT: begin
            if (rsp_taken) state_in = rsp_last_ff ? pn_pkg::ST_IDLE : pn_pkg::ST_EMIT_RD;
         end
         default: state_in = pn_pkg::ST_IDLE;
      endcase
   end

   // Datapath updates and store access
   always_comb begin
      kept_in       = kept_ff;
      comp_in       = comp_ff;
      dots_in       = dots_ff;
      lead_in       = lead_ff;
      ovf_in        = ovf_ff;
      finish_in     = finish_ff;
      emit_idx_in   = emit_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = kept_ff[pn_pkg::ADDR_W-1:0];
      mem_wdata     = q_op.char_byte;
      mem_raddr     = emit_idx_ff;
      q_pop         = 1'b0;

      case (state_ff)
         pn_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_op.kind)
                  pn_pkg::OP_ABS_CHAR: begin
                     // Verbatim copy while it still fits.
                     if (!ovf_ff) begin
                        if (abs_full) begin
                           ovf_in = 1'b1;
                        end else begin
                           mem_we  = 1'b1;
                           kept_in = kept_ff + pn_pkg::LEN_W'(1);
                        end
                     end
                  end
                  pn_pkg::OP_CHAR: begin
                     // Stage the character behind the kept path.
                     lead_in = 1'b0;
                     if (!ovf_ff) begin
                        mem_we    = (pos < pn_pkg::POS_W'(pn_pkg::BUFFER_BYTES));
                        mem_waddr = pos[pn_pkg::ADDR_W-1:0];
                        if (q_op.char_byte == pn_pkg::DOT_CHAR) begin
                           if (comp_ff == '0) dots_in = pn_pkg::DOTS_ONE;
                           else if (dots_ff == pn_pkg::DOTS_ONE) dots_in = pn_pkg::DOTS_TWO;
                           else dots_in = pn_pkg::DOTS_OTHER;
                        end else begin
                           dots_in = pn_pkg::DOTS_OTHER;
                        end
                        if (comp_ff <= BUF_LEN) comp_in = comp_ff + pn_pkg::LEN_W'(1);
                     end
                  end
                  default: begin
                     // Slash or end of path: close the open component.
                     if (q_op.kind == pn_pkg::OP_END) finish_in = 1'b1;
                     if ((q_op.kind == pn_pkg::OP_SLASH && !lead_ff)
                         || (q_op.kind == pn_pkg::OP_END && !cfg.absolute_mode)) begin
                        if (close_app) begin
                           if (app_full) begin
                              ovf_in = 1'b1;
                           end else begin
                              mem_we    = sep && (kept_ff < BUF_LEN);
                              mem_wdata = pn_pkg::SLASH_CHAR;
                              kept_in   = pos[pn_pkg::LEN_W-1:0];
                           end
                        end
                        comp_in = '0;
                        dots_in = pn_pkg::DOTS_OTHER;
                     end
                  end
               endcase
            end
         end
         pn_pkg::ST_POP_RD: begin
            mem_raddr = pn_pkg::ADDR_W'(kept_ff - pn_pkg::LEN_W'(1));
         end
         pn_pkg::ST_POP_CHK: begin
            // Each byte examined is dropped, the separator included.
            kept_in = kept_ff - pn_pkg::LEN_W'(1);
         end
         pn_pkg::ST_FIN: begin
            rsp_last_in   = 1'b1;
            rsp_status_in = 1'b0;
            if (fin_error) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = pn_pkg::NUL_CHAR;
               rsp_status_in = 1'b1;
            end else if (kept_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = cfg.absolute_mode ? pn_pkg::NUL_CHAR : pn_pkg::DOT_CHAR;
            end
         end
         pn_pkg::ST_EMIT_RD: begin
            mem_raddr = emit_idx_ff;
         end
         pn_pkg::ST_EMIT_LD: begin
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = rd_data_ff;
            rsp_status_in = 1'b0;
            rsp_last_in   = ({1'b0, emit_idx_ff} + pn_pkg::LEN_W'(1)) == kept_ff;
         end
         pn_pkg::ST_WAIT: begin
            if (rsp_taken) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  // Path finished: back to the empty-path state.
                  kept_in     = '0;
                  comp_in     = '0;
                  dots_in     = pn_pkg::DOTS_OTHER;
                  lead_in     = 1'b1;
                  ovf_in      = 1'b0;
                  finish_in   = 1'b0;
                  emit_idx_in = '0;
               end else begin
                  emit_idx_in = emit_idx_ff + pn_pkg::ADDR_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pn_pkg::ST_IDLE;
         kept_ff      <= '0;
         comp_ff      <= '0;
         dots_ff      <= pn_pkg::DOTS_OTHER;
         lead_ff      <= 1'b1;
         ovf_ff       <= 1'b0;
         finish_ff    <= 1'b0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         comp_ff      <= comp_in;
         dots_ff      <= dots_in;
         lead_ff      <= lead_in;
         ovf_ff       <= ovf_in;
         finish_ff    <= finish_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Store write port and registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

endmodule

// ===== rtl/path_normalizer.sv =====
`timescale 1ns / 1ps
// Path normaliser top level: configuration registers, front, queue and back.
// Uses pn_pkg, pn_if, pn_front, pn_queue and pn_back.
//
// A path arrives as one character transaction per byte followed by an end
// transaction. Characters are accepted one per cycle while the two-entry
// queue has room; the back part executes one per cycle while idle. A ".."
// component walks back over the store through its registered read port,
// reading and then dropping each byte until it drops a separator or
// reaches the start of the store. The end transaction leaves the queue and
// the finish state ends the path. Each result byte then passes through
// store read, response load and hand-over, which waits for the response
// side. A single-result ending ("." , empty or error) is loaded in the
// finish state and handed over from the wait state. New characters queue
// while results drain until the queue fills. No clearing pass follows reset.
module path_normalizer (
   input  logic      clock,
   input  logic      reset,
   pn_req_if.sink    req_ch,
   pn_rsp_if.source  rsp_ch,
   pn_csr_if.sink    csr_ch
);

   pn_pkg::cfg_type cfg_ff, cfg_in;
   logic            q_push;
   logic            q_full;
   logic            q_pop;
   logic            q_valid;
   pn_pkg::op_type  push_op;
   pn_pkg::op_type  head_op;

   // Register writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            pn_pkg::CSR_ABSOLUTE_MODE:   cfg_in.absolute_mode   = csr_ch.data[0];
            pn_pkg::CSR_OUTPUT_CAPACITY: cfg_in.output_capacity = csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.absolute_mode   <= 1'b0;
         cfg_ff.output_capacity <= pn_pkg::CAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pn_front u_front (
      .req    (req_ch),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_push (q_push),
      .q_op   (push_op)
   );

   pn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (push_op),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_op   (head_op)
   );

   pn_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_op    (head_op),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

// ===== tb/pn_score_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the path normaliser testbench: predicts the response
// transactions of each path and checks the ones the block hands out.
// Depends on pn_pkg for widths, character codes and register indexes.
package pn_score_pkg;
   import pn_pkg::*;

   class path_scoreboard;
      typedef struct packed {
         logic [BYTE_W-1:0] out_byte;
         logic              last;
         logic              status;
      } path_byte_type;

      // Copy of the kept path and the open segment
      logic [BYTE_W-1:0] stored [BUFFER_BYTES];
      logic [LEN_W-1:0]  kept_count;
      logic [LEN_W-1:0]  segment_count;
      dots_type          segment_dots;
      logic              at_root_slashes;
      logic              overflowed;

      // Copy of the configuration registers
      logic              verbatim;
      logic [LEN_W-1:0]  capacity;

      path_byte_type     expected_bytes [$];
      int                mismatches;

      function new();
         foreach (stored[i]) stored[i] = NUL_CHAR;
         verbatim   = 1'b0;
         capacity   = CAP_RESET;
         mismatches = 0;
         restart_path();
      endfunction

      function void restart_path();
         kept_count      = '0;
         segment_count   = '0;
         segment_dots    = DOTS_OTHER;
         at_root_slashes = 1'b1;
         overflowed      = 1'b0;
      endfunction

      // Capacities above the store size behave as the store size.
      function int usable_capacity();
         return (capacity > BUFFER_BYTES) ? BUFFER_BYTES : int'(capacity);
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ABSOLUTE_MODE:   verbatim = data[0];
            CSR_OUTPUT_CAPACITY: capacity = data[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // A slash or the end closes the open segment: "." and empty ones are
      // dropped, ".." removes the last kept segment and its separator.
      function void close_segment();
         int sep;
         if (!overflowed && segment_count != 0 && segment_dots != DOTS_ONE) begin
            if (segment_dots == DOTS_TWO) begin
               while (kept_count > 0 && stored[kept_count - 1] != SLASH_CHAR)
                  kept_count = kept_count - 1'b1;
               if (kept_count > 0)
                  kept_count = kept_count - 1'b1;
            end else begin
               sep = (kept_count > 0) ? 1 : 0;
               if (int'(kept_count) + sep + int'(segment_count) + 1 > usable_capacity()) begin
                  overflowed = 1'b1;
               end else begin
                  if (sep != 0 && kept_count < BUFFER_BYTES)
                     stored[kept_count] = SLASH_CHAR;
                  kept_count = LEN_W'(int'(kept_count) + sep + int'(segment_count));
               end
            end
         end
         segment_count = '0;
         segment_dots  = DOTS_OTHER;
      endfunction

      function void absorb_char(logic [BYTE_W-1:0] c);
         int pos;
         if (verbatim) begin
            if (overflowed)
               return;
            if (int'(kept_count) + 2 > usable_capacity() || kept_count >= BUFFER_BYTES) begin
               overflowed = 1'b1;
               return;
            end
            stored[kept_count] = c;
            kept_count = kept_count + 1'b1;
            return;
         end
         if (c == SLASH_CHAR) begin
            if (!at_root_slashes)
               close_segment();
            return;
         end
         at_root_slashes = 1'b0;
         if (overflowed)
            return;
         // Characters land behind the kept path and its future separator.
         pos = int'(kept_count) + ((kept_count > 0) ? 1 : 0) + int'(segment_count);
         if (pos < BUFFER_BYTES)
            stored[pos] = c;
         if (c == DOT_CHAR) begin
            if (segment_count == 0)
               segment_dots = DOTS_ONE;
            else if (segment_dots == DOTS_ONE)
               segment_dots = DOTS_TWO;
            else
               segment_dots = DOTS_OTHER;
         end else begin
            segment_dots = DOTS_OTHER;
         end
         if (segment_count <= BUFFER_BYTES)
            segment_count = segment_count + 1'b1;
      endfunction

      // The end transaction turns the kept path into response transactions.
      function void emit_path();
         path_byte_type r;
         if (!verbatim)
            close_segment();
         if (usable_capacity() < 2)
            overflowed = 1'b1;
         if (overflowed) begin
            r.out_byte = NUL_CHAR;
            r.last     = 1'b1;
            r.status   = 1'b1;
            expected_bytes.push_back(r);
         end else if (kept_count == 0) begin
            r.out_byte = verbatim ? NUL_CHAR : DOT_CHAR;
            r.last     = 1'b1;
            r.status   = 1'b0;
            expected_bytes.push_back(r);
         end else begin
            for (int k = 0; k < kept_count; k++) begin
               r.out_byte = stored[k];
               r.last     = (k + 1 == kept_count);
               r.status   = 1'b0;
               expected_bytes.push_back(r);
            end
         end
         restart_path();
      endfunction

      function void take_request(logic command, logic [BYTE_W-1:0] char_byte);
         if (command == CMD_END)
            emit_path();
         else
            absorb_char(char_byte);
      endfunction

      function void check_response(logic [BYTE_W-1:0] out_byte, logic last,
                                   logic status);
         path_byte_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: response with none expected: byte %h last %b status %b",
                     $time, out_byte, last, status);
            mismatches++;
            return;
         end
         want = expected_bytes.pop_front();
         if (want.out_byte !== out_byte || want.last !== last || want.status !== status) begin
            $display("%0t: response mismatch: expected byte %h last %b status %b, got byte %h last %b status %b",
                     $time, want.out_byte, want.last, want.status, out_byte, last, status);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the path normaliser testbench: clock, reset, drivers for the
// request and register channels, and the response checker.
// Depends on pn_pkg, pn_if, pn_score_pkg and the path_normalizer block.
module tb_top;
   import pn_pkg::*;
   import pn_score_pkg::*;

   localparam int PHASES        = 11;
   localparam int SETTLE_CYCLES = 200;
   localparam int TIMEOUT_NS    = 5_000_000;

   // Register settings and item budgets per phase; phase 0 runs on reset values.
   localparam logic [CSR_DATA_W-1:0] MODE_WORD [PHASES] =
      '{7'h00, 7'h00, 7'h7F, 7'h02, 7'h01, 7'h00, 7'h7E, 7'h01, 7'h00, 7'h55, 7'h00};
   localparam logic [CSR_DATA_W-1:0] CAP_WORD [PHASES] =
      '{7'd64, 7'd64, 7'd64, 7'd8, 7'd2, 7'd127, 7'd1, 7'd0, 7'd2, 7'd16, 7'd64};
   localparam int ITEM_BUDGET [PHASES] =
      '{0, 6, 25, 6, 4, 6, 4, 4, 4, 6, 6};

   logic clock = 1'b0;
   logic reset = 1'b1;

   pn_req_if req_bus ();
   pn_rsp_if rsp_bus ();
   pn_csr_if csr_bus ();

   path_normalizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   path_scoreboard    board;
   int                send_idle_pct;
   int                rsp_stall_pct;
   int                phase_items;
   logic [BYTE_W-1:0] path_bytes [$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side stalls at random; it changes only at the falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Every accepted response transaction is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_response(rsp_bus.out_byte, rsp_bus.last, rsp_bus.status);
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so back-to-back transactions need no gap.
   task automatic send_request(input logic command, input logic [BYTE_W-1:0] char_byte);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= command;
      req_bus.char_byte <= char_byte;
      do @(posedge clock); while (!req_bus.ready);
      board.take_request(command, char_byte);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      board.write_register(index, data);
      @(negedge clock);
   endtask

   task automatic send_path();
      foreach (path_bytes[i])
         send_request(CMD_CHAR, path_bytes[i]);
      send_request(CMD_END, BYTE_W'($urandom_range(0, 255)));
      phase_items += path_bytes.size() + 1;
   endtask

   task automatic send_text(input string text);
      path_bytes.delete();
      foreach (text[i])
         path_bytes.push_back(text[i]);
      send_path();
   endtask

   // Mostly letters, sometimes any byte that is not a slash.
   function automatic logic [BYTE_W-1:0] name_byte();
      logic [BYTE_W-1:0] b;
      if ($urandom_range(0, 3) == 0) begin
         b = BYTE_W'($urandom_range(0, 255));
         if (b == SLASH_CHAR)
            b = NUL_CHAR;
      end else begin
         b = BYTE_W'(8'h61 + $urandom_range(0, 25));
      end
      return b;
   endfunction

   // A well-formed path: optional leading slashes, then segments that are
   // empty, ".", "..", "..." or names, some of them long.
   task automatic build_tidy_path();
      int parts;
      int kind;
      int len;
      path_bytes.delete();
      repeat ($urandom_range(0, 2)) path_bytes.push_back(SLASH_CHAR);
      parts = $urandom_range(0, 6);
      for (int i = 0; i < parts; i++) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0: ;
            1: path_bytes.push_back(DOT_CHAR);
            2, 3: begin
               path_bytes.push_back(DOT_CHAR);
               path_bytes.push_back(DOT_CHAR);
            end
            4: repeat (3) path_bytes.push_back(DOT_CHAR);
            default: begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
               repeat (len) path_bytes.push_back(name_byte());
            end
         endcase
         if (i + 1 < parts || $urandom_range(0, 3) == 0)
            path_bytes.push_back(SLASH_CHAR);
      end
   endtask

   // Noise weighted towards slashes and dots.
   task automatic build_noise_path();
      int len;
      int pick;
      path_bytes.delete();
      len = $urandom_range(0, 20);
      repeat (len) begin
         pick = $urandom_range(0, 9);
         if (pick < 4)
            path_bytes.push_back(SLASH_CHAR);
         else if (pick < 6)
            path_bytes.push_back(DOT_CHAR);
         else
            path_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic build_verbatim_path(input int len);
      path_bytes.delete();
      repeat (len) path_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
   endtask

   // Registers change only once every response has come and the block has
   // had time to finish any pending work.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (board.expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      board             = new();
      send_idle_pct     = 0;
      rsp_stall_pct     = 0;
      phase_items       = 0;
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_CHAR;
      req_bus.char_byte = NUL_CHAR;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_ABSOLUTE_MODE;
      csr_bus.data      = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed paths on the reset settings: dot and dot-dot segments,
      // a pop at the root, the empty path, "..." and the extreme bytes.
      send_text("/a/./b/../c");
      send_text("");
      send_text("../x");
      send_text("...");
      path_bytes.delete();
      path_bytes.push_back(NUL_CHAR);
      path_bytes.push_back(8'hFF);
      send_path();

      for (int p = 1; p < PHASES; p++) begin
         wait_for_drain();
         csr_write(CSR_ABSOLUTE_MODE, MODE_WORD[p]);
         csr_write(CSR_OUTPUT_CAPACITY, CAP_WORD[p]);
         csr_bus.valid <= 1'b0;
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         phase_items = 0;

         // Verbatim paths at the full store: one that just fits, one byte
         // too many, and the empty one.
         if (p == 2) begin
            build_verbatim_path(BUFFER_BYTES - 1);
            send_path();
            build_verbatim_path(BUFFER_BYTES);
            send_path();
            build_verbatim_path(0);
            send_path();
         end

         while (phase_items < ITEM_BUDGET[p]) begin
            if (MODE_WORD[p][0]) begin
               if ($urandom_range(0, 9) < 8)
                  build_verbatim_path(($urandom_range(0, 9) == 0) ?
                                      $urandom_range(13, 20) : $urandom_range(0, 12));
               else
                  build_tidy_path();
            end else begin
               if ($urandom_range(0, 9) < 7)
                  build_tidy_path();
               else
                  build_noise_path();
            end
            send_path();
         end
      end

      wait_for_drain();
      if (board.mismatches == 0 && board.expected_bytes.size() == 0)
         $display("[path_normalizer] OK");
      else
         $display("[path_normalizer] ERROR");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[path_normalizer] ERROR");
      $finish;
   end

endmodule

// ===== path_normalizer.f =====
rtl/pn_pkg.sv
rtl/pn_if.sv
rtl/pn_front.sv
rtl/pn_queue.sv
rtl/pn_back.sv
rtl/path_normalizer.sv
tb/pn_score_pkg.sv
tb/tb_top.sv
